// ===== hdl/psg_pkg.sv =====
// Shared types and constants for the three-voice sound generator.
// No dependencies; imported by every module of the block.
package psg_pkg;

    localparam int unsigned NUM_VOICES = 3;

    // item codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // configuration register indexes
    localparam logic CFG_TICK_WHOLE = 1'b0;
    localparam logic CFG_TICK_FRAC  = 1'b1;

    localparam logic [7:0]  TICK_WHOLE_RESET = 8'd2;
    localparam logic [15:0] TICK_FRAC_RESET  = 16'd31457;

    // chip register addresses
    localparam logic [3:0] REG_TONE_A_FINE   = 4'd0;
    localparam logic [3:0] REG_TONE_C_COARSE = 4'd5;
    localparam logic [3:0] REG_NOISE_PER     = 4'd6;
    localparam logic [3:0] REG_MIXER         = 4'd7;
    localparam logic [3:0] REG_VOL_A         = 4'd8;
    localparam logic [3:0] REG_ENV_FINE      = 4'd11;
    localparam logic [3:0] REG_ENV_COARSE    = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE     = 4'd13;

    // envelope shape states
    localparam logic [4:0] ENV_ALT_DOWN  = 5'd10;
    localparam logic [4:0] ENV_ALT_UP    = 5'd14;
    localparam logic [4:0] ENV_HOLD_LOW  = 5'd16;
    localparam logic [4:0] ENV_HOLD_HIGH = 5'd17;

    localparam logic [16:0] LFSR_RESET = 17'd1;

    localparam logic [15:0] VOL_TABLE [16] = '{
        16'h0000, 16'h0385, 16'h053D, 16'h0770, 16'h0AD7, 16'h0FD5, 16'h15B0, 16'h230C,
        16'h2B4C, 16'h43C1, 16'h5A4B, 16'h732F, 16'h9204, 16'hAFF1, 16'hD921, 16'hFFFE
    };

    // Q16 pan weights, voices A, B, C
    localparam logic [15:0] PAN_LEFT  [NUM_VOICES] = '{16'd29491, 16'd32768, 16'd3277};
    localparam logic [15:0] PAN_RIGHT [NUM_VOICES] = '{16'd3277, 16'd32768, 16'd29491};

    localparam logic [16:0] SAMPLE_FULL = 17'd32767;

    typedef struct packed {
        logic       action;
        logic [3:0] reg_addr;
        logic [7:0] reg_value;
    } psg_in_t;

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic [3:0]         level_a;
        logic [3:0]         level_b;
        logic [3:0]         level_c;
    } psg_out_t;

    typedef struct packed {
        logic [3:0] level_a;
        logic [3:0] level_b;
        logic [3:0] level_c;
    } psg_levels_t;

endpackage

// ===== hdl/psg_core.sv =====
// Chip state and per-item update: register file, tone/noise dividers,
// LFSR, envelope and voice mixing into three registered levels. Uses psg_pkg.
module psg_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [15:0]          cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  psg_pkg::psg_in_t     s_data,
    output logic                 lvl_valid,
    input  logic                 lvl_ready,
    output psg_pkg::psg_levels_t lvl_data
);
    import psg_pkg::*;

    logic [7:0]  tick_whole_reg, tick_whole_next;
    logic [15:0] tick_frac_reg, tick_frac_next;
    logic [7:0]  reg_file_reg [16];
    logic [7:0]  reg_file_next [16];
    logic [15:0] tone_count_reg [NUM_VOICES];
    logic [15:0] tone_count_next [NUM_VOICES];
    logic [NUM_VOICES-1:0] tone_level_reg, tone_level_next;
    logic [15:0] noise_count_reg, noise_count_next;
    logic        noise_gate_reg, noise_gate_next;
    logic [16:0] lfsr_reg, lfsr_next;
    logic [20:0] env_count_reg, env_count_next;
    logic [3:0]  env_phase_reg, env_phase_next;
    logic [4:0]  env_state_reg, env_state_next;
    logic [15:0] frac_reg, frac_next;
    logic        lvl_valid_reg, lvl_valid_next;
    psg_levels_t lvl_reg, lvl_next;

    logic        accept;
    logic [16:0] frac_sum;
    logic [8:0]  ticks;
    logic [16:0] step;
    logic [20:0] env_sum;
    logic [20:0] env_per;
    logic        noise_bit;
    logic [3:0]  env_lvl;
    logic [7:0]  mixer;
    logic [7:0]  vol;
    logic        tdis, ndis, voice_on;
    logic [3:0]  lv [NUM_VOICES];

    // returns {toggle, new count}
    function automatic logic [16:0] div_step(logic [15:0] cnt, logic [15:0] per,
                                             logic [8:0] tk);
        logic [15:0] c;
        logic        tog;
        tog = 1'b0;
        c   = cnt + 16'(tk);
        if ((16'(tk) > per) && (per != 16'd0)) begin
            tog = 1'b1;
            c   = 16'd0;
        end else if (c >= per) begin
            tog = 1'b1;
            c   = c - per;
        end
        return {tog, c};
    endfunction

    function automatic logic [4:0] env_follow(logic [4:0] s);
        logic [4:0] r;
        case (s) inside
            [5'd0:5'd7], 5'd9, 5'd15: r = ENV_HOLD_LOW;
            5'd11, 5'd13:             r = ENV_HOLD_HIGH;
            ENV_ALT_DOWN:             r = ENV_ALT_UP;
            ENV_ALT_UP:               r = ENV_ALT_DOWN;
            default:                  r = s;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] env_value(logic [4:0] s, logic [3:0] ph);
        logic [3:0] r;
        case (s) inside
            [5'd0:5'd3], [5'd8:5'd11]:  r = 4'd15 - ph;
            [5'd4:5'd7], [5'd12:5'd15]: r = ph;
            ENV_HOLD_HIGH:              r = 4'd15;
            default:                    r = 4'd0;
        endcase
        return r;
    endfunction

    assign s_ready   = !lvl_valid_reg || lvl_ready;
    assign accept    = s_valid && s_ready;
    assign lvl_valid = lvl_valid_reg;
    assign lvl_data  = lvl_reg;

    always_comb begin
        tick_whole_next  = tick_whole_reg;
        tick_frac_next   = tick_frac_reg;
        reg_file_next    = reg_file_reg;
        tone_count_next  = tone_count_reg;
        tone_level_next  = tone_level_reg;
        noise_count_next = noise_count_reg;
        noise_gate_next  = noise_gate_reg;
        lfsr_next        = lfsr_reg;
        env_count_next   = env_count_reg;
        env_phase_next   = env_phase_reg;
        env_state_next   = env_state_reg;
        frac_next        = frac_reg;
        lvl_next         = lvl_reg;
        lvl_valid_next   = lvl_valid_reg && !lvl_ready;

        frac_sum  = {1'b0, frac_reg} + {1'b0, tick_frac_reg};
        ticks     = {1'b0, tick_whole_reg} + {8'd0, frac_sum[16]};
        step      = '0;
        env_sum   = env_count_reg + 21'(ticks);
        env_per   = {1'b0, reg_file_reg[REG_ENV_COARSE], reg_file_reg[REG_ENV_FINE], 4'd0};
        noise_bit = 1'b0;
        env_lvl   = '0;
        mixer     = reg_file_reg[REG_MIXER];
        vol       = '0;
        tdis      = 1'b0;
        ndis      = 1'b0;
        voice_on  = 1'b0;
        for (int i = 0; i < NUM_VOICES; i++) begin
            lv[i] = '0;
        end

        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_TICK_WHOLE: tick_whole_next = cfg_wdata[7:0];
                CFG_TICK_FRAC:  tick_frac_next  = cfg_wdata;
                default:        tick_whole_next = tick_whole_reg;
            endcase
        end

        if (accept && (s_data.action == ACT_WRITE)) begin
            reg_file_next[s_data.reg_addr] = s_data.reg_value;
            unique case (s_data.reg_addr) inside
                [REG_TONE_A_FINE:REG_TONE_C_COARSE]:
                    tone_count_next[s_data.reg_addr[2:1]] = 16'd0;
                REG_NOISE_PER: noise_count_next = 16'd0;
                REG_ENV_SHAPE: env_state_next = {1'b0, s_data.reg_value[3:0]};
                default:       noise_count_next = noise_count_reg;
            endcase
        end else if (accept) begin
            frac_next = frac_sum[15:0];

            for (int i = 0; i < NUM_VOICES; i++) begin
                step = div_step(tone_count_reg[i],
                                {4'd0, reg_file_reg[2*i+1][3:0], reg_file_reg[2*i]}, ticks);
                tone_count_next[i] = step[15:0];
                tone_level_next[i] = tone_level_reg[i] ^ step[16];
            end

            step = div_step(noise_count_reg, {8'd0, reg_file_reg[REG_NOISE_PER]}, ticks);
            noise_count_next = step[15:0];
            noise_gate_next  = noise_gate_reg ^ step[16];
            lfsr_next = {lfsr_reg[0] ^ lfsr_reg[3], lfsr_reg[16:1]};
            noise_bit = noise_gate_next & lfsr_next[0];

            env_count_next = env_sum;
            if (env_sum > env_per) begin
                env_count_next = env_sum - env_per;
                if (env_phase_reg == 4'd15) begin
                    env_phase_next = 4'd0;
                    env_state_next = env_follow(env_state_reg);
                end else begin
                    env_phase_next = env_phase_reg + 4'd1;
                end
            end
            env_lvl = env_value(env_state_next, env_phase_next);

            for (int i = 0; i < NUM_VOICES; i++) begin
                tdis     = mixer[i];
                ndis     = mixer[i+3];
                voice_on = (tdis || tone_level_next[i]) && (ndis || noise_bit)
                           && !(tdis && ndis);
                vol      = reg_file_reg[REG_VOL_A + 4'(i)];
                lv[i]    = voice_on ? (vol[4] ? env_lvl : vol[3:0]) : 4'd0;
            end
            lvl_next       = '{level_a: lv[0], level_b: lv[1], level_c: lv[2]};
            lvl_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_whole_reg  <= TICK_WHOLE_RESET;
            tick_frac_reg   <= TICK_FRAC_RESET;
            for (int i = 0; i < 16; i++) begin
                reg_file_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_VOICES; i++) begin
                tone_count_reg[i] <= '0;
            end
            tone_level_reg  <= '0;
            noise_count_reg <= '0;
            noise_gate_reg  <= 1'b0;
            lfsr_reg        <= LFSR_RESET;
            env_count_reg   <= '0;
            env_phase_reg   <= '0;
            env_state_reg   <= '0;
            frac_reg        <= '0;
            lvl_valid_reg   <= 1'b0;
        end else begin
            tick_whole_reg  <= tick_whole_next;
            tick_frac_reg   <= tick_frac_next;
            reg_file_reg    <= reg_file_next;
            tone_count_reg  <= tone_count_next;
            tone_level_reg  <= tone_level_next;
            noise_count_reg <= noise_count_next;
            noise_gate_reg  <= noise_gate_next;
            lfsr_reg        <= lfsr_next;
            env_count_reg   <= env_count_next;
            env_phase_reg   <= env_phase_next;
            env_state_reg   <= env_state_next;
            frac_reg        <= frac_next;
            lvl_valid_reg   <= lvl_valid_next;
        end
        lvl_reg <= lvl_next;
    end

endmodule

// ===== hdl/psg_mixer.sv =====
// Output stage: level table, Q16 pan weighting and rounding into the
// registered stereo result. Uses psg_pkg.
module psg_mixer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 lvl_valid,
    output logic                 lvl_ready,
    input  psg_pkg::psg_levels_t lvl_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output psg_pkg::psg_out_t    m_data
);
    import psg_pkg::*;

    logic     m_valid_reg, m_valid_next;
    psg_out_t m_data_reg, m_data_next;
    logic [3:0]  lv [NUM_VOICES];
    logic [32:0] acc_left, acc_right;
    logic [16:0] rnd_left, rnd_right;

    function automatic logic [32:0] weigh(logic [15:0] w, logic [3:0] l);
        return 33'(32'(w) * 32'(VOL_TABLE[l]));
    endfunction

    assign lvl_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        lv[0] = lvl_data.level_a;
        lv[1] = lvl_data.level_b;
        lv[2] = lvl_data.level_c;
        acc_left  = 33'd32768;
        acc_right = 33'd32768;
        for (int i = 0; i < NUM_VOICES; i++) begin
            acc_left  = acc_left + weigh(PAN_LEFT[i], lv[i]);
            acc_right = acc_right + weigh(PAN_RIGHT[i], lv[i]);
        end
        rnd_left  = SAMPLE_FULL - acc_left[32:16];
        rnd_right = SAMPLE_FULL - acc_right[32:16];

        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (lvl_valid && lvl_ready) begin
            m_data_next.left_sample  = rnd_left[15:0];
            m_data_next.right_sample = rnd_right[15:0];
            m_data_next.level_a      = lvl_data.level_a;
            m_data_next.level_b      = lvl_data.level_b;
            m_data_next.level_c      = lvl_data.level_c;
            m_valid_next             = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

endmodule

// ===== hdl/psg_three_voice_sound_generator_unit.sv =====
// Top level of the three-voice sound generator: state/update stage feeding
// the stereo output stage. Uses psg_pkg, psg_core and psg_mixer.
// Throughput: one item per cycle, write or tick, while the result side takes transfers.
// A tick's result is registered first in the level register, then in the output register;
// a register write gives no result and takes effect for the next item.
// Reset: synchronous on aresetn low; all chip state clears, LFSR loads 1, tick config
// returns to 2 + 31457/65536, and both pipeline stages empty.
module psg_three_voice_sound_generator_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [15:0]       cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  psg_pkg::psg_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output psg_pkg::psg_out_t m_data
);
    import psg_pkg::*;

    logic        lvl_valid;
    logic        lvl_ready;
    psg_levels_t lvl_data;

    psg_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .lvl_valid (lvl_valid),
        .lvl_ready (lvl_ready),
        .lvl_data  (lvl_data)
    );

    psg_mixer u_mixer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .lvl_valid (lvl_valid),
        .lvl_ready (lvl_ready),
        .lvl_data  (lvl_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== hdl/psg_checker.sv =====
// Port-level checks for the sound generator top level, and their bind.
// Uses psg_pkg; attaches to psg_three_voice_sound_generator_unit.
module psg_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input psg_pkg::psg_out_t m_data
);
    import psg_pkg::*;

    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with result side empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.level_a == 4'd0 && m_data.level_b == 4'd0
        && m_data.level_c == 4'd0 |-> m_data.left_sample == 16'sd32767
        && m_data.right_sample == 16'sd32767)
        else $error("silent voices give nonzero sample");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.level_a == m_data.level_c
        |-> m_data.left_sample == m_data.right_sample)
        else $error("symmetric levels give unequal channels");

endmodule

bind psg_three_voice_sound_generator_unit psg_checker u_psg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
